FILE: hw/rtl/rv32x_pkg.sv
// Shared types and constants for the RV32I execute stage.
// Holds the operation codes and the packed item layouts; depends on nothing.
package rv32x_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned OP_W     = 6;
  localparam int unsigned SHAMT_W  = 5;
  localparam int unsigned IN_W     = 136;  // 134 payload bits, padded to bytes
  localparam int unsigned OUT_W    = 104;  // 99 payload bits, padded to bytes

  localparam logic [XLEN-1:0] INSN_BYTES = 32'd4;

  typedef enum logic [OP_W-1:0] {
    OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,
    OP_LB    = 6'd10, OP_LH    = 6'd11, OP_LW    = 6'd12, OP_LBU   = 6'd13,
    OP_LHU   = 6'd14, OP_SB    = 6'd15, OP_SH    = 6'd16, OP_SW    = 6'd17,
    OP_ADDI  = 6'd18, OP_SLTI  = 6'd19, OP_SLTIU = 6'd20, OP_XORI  = 6'd21,
    OP_ORI   = 6'd22, OP_ANDI  = 6'd23, OP_SLLI  = 6'd24, OP_SRAI  = 6'd25,
    OP_SRLI  = 6'd26,
    OP_ADD   = 6'd27, OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30,
    OP_SLTU  = 6'd31, OP_XOR   = 6'd32, OP_OR    = 6'd33, OP_AND   = 6'd34,
    OP_SRA   = 6'd35, OP_SRL   = 6'd36, OP_UNSUP = 6'd37
  } op_t;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [XLEN-1:0] immediate;
    logic [XLEN-1:0] src2_value;
    logic [XLEN-1:0] src1_value;
    logic [XLEN-1:0] pc;
    logic [OP_W-1:0] op;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic            illegal;
    logic            mem_access;
    logic [XLEN-1:0] eff_address;
    logic [XLEN-1:0] next_pc;
    logic            dest_write;
    logic [XLEN-1:0] dest_value;
  } res_item_t;

endpackage

FILE: hw/rtl/rv32i_execute_stage_core.sv
// RV32I execute stage: ALU, branch resolution, jump targets and load/store address.
// Depends on rv32x_pkg for operation codes and item layouts.
// An accepted item is registered in stage 1, then its result in stage 2, which drives
// out_tvalid. Takes one item per cycle while out_tready stays high.
// Stage 1 registers the accepted item, stage 2 registers the computed result; the
// adders, comparators and barrel shifter sit between them.
// Reset (rst_n low, synchronous) empties both stages; payload registers keep their data.
module rv32i_execute_stage_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata, lowest bit up: op[5:0], pc[37:6], src1_value[69:38],
  // src2_value[101:70], immediate[133:102], zero pad[135:134]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rv32x_pkg::IN_W-1:0]    in_tdata,
  // out_tdata, lowest bit up: dest_value[31:0], dest_write[32], next_pc[64:33],
  // eff_address[96:65], mem_access[97], illegal[98], zero pad[103:99]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rv32x_pkg::OUT_W-1:0]   out_tdata
);

  localparam int unsigned IN_BITS  = $bits(rv32x_pkg::in_item_t);
  localparam int unsigned OUT_BITS = $bits(rv32x_pkg::res_item_t);

  // Stage 1: accepted item
  logic                  s1_vld_r;
  rv32x_pkg::in_item_t   s1_item_r;
  // Stage 2: finished result
  logic                  s2_vld_r;
  rv32x_pkg::res_item_t  s2_res_r;
  rv32x_pkg::res_item_t  s2_res_nxt;

  logic s2_free;
  logic s1_adv;

  // Result stage frees up when empty or being drained this cycle; the item stage
  // advances into it then, so a new item can enter in every cycle while the output is not stalled.
  assign s2_free   = !s2_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && s2_free;
  assign in_tready = !s1_vld_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_free) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  // Payload: hold while stalled, load on advance
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= rv32x_pkg::in_item_t'(in_tdata[IN_BITS-1:0]);
    end
    if (s1_adv) begin
      s2_res_r <= s2_res_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute logic
  // ---------------------------------------------------------------------------
  logic [31:0] a, b, imm, pc;
  logic [31:0] seq_pc, br_target, a_plus_imm;
  logic [4:0]  shamt_i, shamt_r;
  logic        lt_s_ab, lt_u_ab, lt_s_ai, lt_u_ai, take;

  assign a          = s1_item_r.src1_value;
  assign b          = s1_item_r.src2_value;
  assign imm        = s1_item_r.immediate;
  assign pc         = s1_item_r.pc;
  assign seq_pc     = pc + rv32x_pkg::INSN_BYTES;
  assign br_target  = pc + imm;
  assign a_plus_imm = a + imm;
  assign shamt_i    = imm[rv32x_pkg::SHAMT_W-1:0];
  assign shamt_r    = b[rv32x_pkg::SHAMT_W-1:0];
  assign lt_s_ab    = $signed(a) < $signed(b);
  assign lt_u_ab    = a < b;
  assign lt_s_ai    = $signed(a) < $signed(imm);
  assign lt_u_ai    = a < imm;

  always_comb begin
    s2_res_nxt             = '0;
    s2_res_nxt.dest_write  = 1'b1;
    s2_res_nxt.next_pc     = seq_pc;
    take                   = 1'b0;

    unique case (rv32x_pkg::op_t'(s1_item_r.op))
      rv32x_pkg::OP_LUI:   s2_res_nxt.dest_value = imm;
      rv32x_pkg::OP_AUIPC: s2_res_nxt.dest_value = br_target;
      rv32x_pkg::OP_JAL: begin
        s2_res_nxt.dest_value = seq_pc;
        s2_res_nxt.next_pc    = br_target;
      end
      rv32x_pkg::OP_JALR: begin
        s2_res_nxt.dest_value = seq_pc;
        s2_res_nxt.next_pc    = {a_plus_imm[31:1], 1'b0};  // drop bit 0
      end
      rv32x_pkg::OP_BEQ, rv32x_pkg::OP_BNE, rv32x_pkg::OP_BLT,
      rv32x_pkg::OP_BGE, rv32x_pkg::OP_BLTU, rv32x_pkg::OP_BGEU: begin
        unique case (rv32x_pkg::op_t'(s1_item_r.op))
          rv32x_pkg::OP_BEQ:  take = (a == b);
          rv32x_pkg::OP_BNE:  take = (a != b);
          rv32x_pkg::OP_BLT:  take = lt_s_ab;
          rv32x_pkg::OP_BGE:  take = !lt_s_ab;
          rv32x_pkg::OP_BLTU: take = lt_u_ab;
          default:            take = !lt_u_ab;
        endcase
        s2_res_nxt.dest_write = 1'b0;
        s2_res_nxt.next_pc    = take ? br_target : seq_pc;
      end
      rv32x_pkg::OP_LB, rv32x_pkg::OP_LH, rv32x_pkg::OP_LW, rv32x_pkg::OP_LBU,
      rv32x_pkg::OP_LHU, rv32x_pkg::OP_SB, rv32x_pkg::OP_SH, rv32x_pkg::OP_SW: begin
        // Loaded data arrives later; this stage only forms the address
        s2_res_nxt.dest_write  = 1'b0;
        s2_res_nxt.eff_address = a_plus_imm;
        s2_res_nxt.mem_access  = 1'b1;
      end
      rv32x_pkg::OP_ADDI:  s2_res_nxt.dest_value = a_plus_imm;
      rv32x_pkg::OP_SLTI:  s2_res_nxt.dest_value = {31'd0, lt_s_ai};
      rv32x_pkg::OP_SLTIU: s2_res_nxt.dest_value = {31'd0, lt_u_ai};
      rv32x_pkg::OP_XORI:  s2_res_nxt.dest_value = a ^ imm;
      rv32x_pkg::OP_ORI:   s2_res_nxt.dest_value = a | imm;
      rv32x_pkg::OP_ANDI:  s2_res_nxt.dest_value = a & imm;
      rv32x_pkg::OP_SLLI:  s2_res_nxt.dest_value = a << shamt_i;
      rv32x_pkg::OP_SRAI:  s2_res_nxt.dest_value = $unsigned($signed(a) >>> shamt_i);
      rv32x_pkg::OP_SRLI:  s2_res_nxt.dest_value = a >> shamt_i;
      rv32x_pkg::OP_ADD:   s2_res_nxt.dest_value = a + b;
      rv32x_pkg::OP_SUB:   s2_res_nxt.dest_value = a - b;
      rv32x_pkg::OP_SLL:   s2_res_nxt.dest_value = a << shamt_r;
      rv32x_pkg::OP_SLT:   s2_res_nxt.dest_value = {31'd0, lt_s_ab};
      rv32x_pkg::OP_SLTU:  s2_res_nxt.dest_value = {31'd0, lt_u_ab};
      rv32x_pkg::OP_XOR:   s2_res_nxt.dest_value = a ^ b;
      rv32x_pkg::OP_OR:    s2_res_nxt.dest_value = a | b;
      rv32x_pkg::OP_AND:   s2_res_nxt.dest_value = a & b;
      rv32x_pkg::OP_SRA:   s2_res_nxt.dest_value = $unsigned($signed(a) >>> shamt_r);
      rv32x_pkg::OP_SRL:   s2_res_nxt.dest_value = a >> shamt_r;
      default: begin
        // Unsupported and unknown codes: flag and fall through to pc + 4
        s2_res_nxt.dest_write = 1'b0;
        s2_res_nxt.illegal    = 1'b1;
      end
    endcase
  end

  assign out_tvalid = s2_vld_r;
  assign out_tdata  = {{(rv32x_pkg::OUT_W - OUT_BITS){1'b0}}, s2_res_r};

endmodule
